// File: src/wsa_pkg.sv
package wsa_pkg;

  // window depth and field widths
  localparam int WINDOW  = 300;
  localparam int CNT_W   = 8;
  localparam int TIRE_W  = 10;
  localparam int SPEED_W = 20;
  localparam int CFG_IDX_W = 8;

  // ring pointer, sample count and running sum widths
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int SAMP_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * (2 ** CNT_W - 1) + 1);

  // speed scale: km/h = S*T*18 / (5*n), mph = S*T*180000 / (80467*n)
  localparam int K_W = 18;
  localparam int D_W = 17;
  localparam logic [K_W-1:0] K_METRIC = K_W'(18);
  localparam logic [D_W-1:0] D_METRIC = D_W'(5);
  localparam logic [K_W-1:0] K_MPH    = K_W'(180000);
  localparam logic [D_W-1:0] D_MPH    = D_W'(80467);

  // datapath widths of the speed unit
  localparam int PROD_W = SUM_W + TIRE_W;
  localparam int NUM_W  = PROD_W + K_W;
  localparam int DEN_W  = SAMP_W + D_W;
  localparam int STEP_W = $clog2(SPEED_W);

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // request types on the input channel
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIRE_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE = CFG_IDX_W'(1);

  // window status toward the sequencer
  typedef struct packed {
    logic [SUM_W-1:0]  recent_sum;
    logic [SUM_W-1:0]  window_sum;
    logic [SAMP_W-1:0] samples;
  } wnd_status_t;

  // speed unit request
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  sum;
    logic [SAMP_W-1:0] n;
  } spd_req_t;

  // speed unit response
  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] speed;
  } spd_rsp_t;

endpackage

// File: src/wsa_window.sv
module wsa_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      add_i,
  input  logic [wsa_pkg::CNT_W-1:0] count_i,
  output wsa_pkg::wnd_status_t      status_o
);

  logic [wsa_pkg::CNT_W-1:0]  count_ring_r [wsa_pkg::WINDOW];
  logic [wsa_pkg::CNT_W-1:0]  rd_data_r;
  logic [wsa_pkg::CNT_W-1:0]  cnt_r;
  logic                       upd_r;
  logic [wsa_pkg::PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [wsa_pkg::SAMP_W-1:0] samples_r, samples_nxt;
  logic [wsa_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [wsa_pkg::CNT_W-1:0]  rec0_r, rec1_r, rec2_r;
  logic                       full;

  // ring memory: read the oldest slot on add, write the new count in the cycle after
  always_ff @(posedge clk) begin
    if (add_i) begin
      rd_data_r <= count_ring_r[ptr_r];
      cnt_r     <= count_i;
    end
    if (upd_r) begin
      count_ring_r[ptr_r] <= cnt_r;
    end
  end

  // next sum, sample count and pointer
  always_comb begin
    full        = (samples_r == wsa_pkg::SAMP_W'(wsa_pkg::WINDOW));
    samples_nxt = full ? samples_r : samples_r + wsa_pkg::SAMP_W'(1);
    sum_nxt     = sum_r + wsa_pkg::SUM_W'(cnt_r);
    if (full) begin
      sum_nxt = sum_nxt - wsa_pkg::SUM_W'(rd_data_r);
    end
    ptr_nxt = (ptr_r == wsa_pkg::PTR_W'(wsa_pkg::WINDOW - 1)) ? '0
                                                              : ptr_r + wsa_pkg::PTR_W'(1);
  end

  // window state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r     <= 1'b0;
      ptr_r     <= '0;
      samples_r <= '0;
      sum_r     <= '0;
      rec0_r    <= '0;
      rec1_r    <= '0;
      rec2_r    <= '0;
    end else begin
      upd_r <= add_i;
      if (upd_r) begin
        ptr_r     <= ptr_nxt;
        samples_r <= samples_nxt;
        sum_r     <= sum_nxt;
        rec2_r    <= rec1_r;
        rec1_r    <= rec0_r;
        rec0_r    <= cnt_r;
      end
    end
  end

  assign status_o.recent_sum = wsa_pkg::SUM_W'(rec0_r) + wsa_pkg::SUM_W'(rec1_r)
                             + wsa_pkg::SUM_W'(rec2_r);
  assign status_o.window_sum = sum_r;
  assign status_o.samples    = samples_r;

endmodule

// File: src/wsa_speed.sv
module wsa_speed (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wsa_pkg::TIRE_W-1:0] tire_i,
  input  logic                       metric_i,
  input  wsa_pkg::spd_req_t          req_i,
  output wsa_pkg::spd_rsp_t          rsp_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_CHK  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } spd_state_t;

  spd_state_t                  state_r;
  logic [wsa_pkg::SUM_W-1:0]   sum_r;
  logic [wsa_pkg::SAMP_W-1:0]  n_r;
  logic [wsa_pkg::K_W-1:0]     k_r;
  logic [wsa_pkg::D_W-1:0]     d_r;
  logic [wsa_pkg::PROD_W-1:0]  prod_r;
  logic [wsa_pkg::NUM_W-1:0]   num_r;
  logic [wsa_pkg::DEN_W-1:0]   den_r;
  logic [wsa_pkg::DEN_W-1:0]   rem_r;
  logic [wsa_pkg::SPEED_W-1:0] lo_r;
  logic [wsa_pkg::SPEED_W-1:0] q_r;
  logic [wsa_pkg::STEP_W-1:0]  step_r;
  logic [wsa_pkg::NUM_W-1:0]   hi_ext;
  logic [wsa_pkg::DEN_W:0]     trial;
  logic [wsa_pkg::DEN_W:0]     diff;
  logic                        take;

  // quotient overflow check and one restoring-divide step
  always_comb begin
    hi_ext = num_r >> wsa_pkg::SPEED_W;
    trial  = {rem_r, lo_r[wsa_pkg::SPEED_W-1]};
    diff   = trial - {1'b0, den_r};
    take   = (trial >= {1'b0, den_r});
  end

  // sequencer over multiply, check and shift-subtract divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_i.start) begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1:  state_r <= S_MUL2;
        S_MUL2:  state_r <= S_CHK;
        S_CHK: begin
          state_r <= (hi_ext >= wsa_pkg::NUM_W'(den_r)) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (step_r == wsa_pkg::STEP_W'(wsa_pkg::SPEED_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sum_r <= req_i.sum;
        n_r   <= req_i.n;
        k_r   <= metric_i ? wsa_pkg::K_METRIC : wsa_pkg::K_MPH;
        d_r   <= metric_i ? wsa_pkg::D_METRIC : wsa_pkg::D_MPH;
      end
      S_MUL1: begin
        prod_r <= wsa_pkg::PROD_W'(sum_r) * wsa_pkg::PROD_W'(tire_i);
        den_r  <= wsa_pkg::DEN_W'(n_r) * wsa_pkg::DEN_W'(d_r);
      end
      S_MUL2: begin
        num_r <= wsa_pkg::NUM_W'(prod_r) * wsa_pkg::NUM_W'(k_r);
      end
      S_CHK: begin
        rem_r  <= hi_ext[wsa_pkg::DEN_W-1:0];
        lo_r   <= num_r[wsa_pkg::SPEED_W-1:0];
        step_r <= '0;
        q_r    <= wsa_pkg::SPEED_MAX;
      end
      S_DIV: begin
        rem_r  <= take ? diff[wsa_pkg::DEN_W-1:0] : trial[wsa_pkg::DEN_W-1:0];
        lo_r   <= {lo_r[wsa_pkg::SPEED_W-2:0], 1'b0};
        q_r    <= {q_r[wsa_pkg::SPEED_W-2:0], take};
        step_r <= step_r + wsa_pkg::STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done  = (state_r == S_DONE);
  assign rsp_o.speed = q_r;

endmodule

// File: src/wheel_speed_window_averager.sv
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | in_req_type, in_pulse_count
// out_    | output    | out_valid / out_stall | out_current_speed, out_average_speed
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// an add transaction does one ring read, then the window update
// a report runs the shared multiply/divide unit for the recent mean, then for the window mean
// if it is not empty (two multiplies, overflow check, 20 divide steps unless it saturates)
// rst_n is synchronous; the ring holds no reset, the window counters and sums clear
// in_stall is high while an item is in work; a result waits in the output
// register under out_stall while the next transaction is accepted
module wheel_speed_window_averager (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [wsa_pkg::CNT_W-1:0]     in_pulse_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsa_pkg::SPEED_W-1:0]   out_current_speed,
  output logic [wsa_pkg::SPEED_W-1:0]   out_average_speed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsa_pkg::TIRE_W-1:0]    cfg_data
);

  typedef enum logic [6:0] {
    T_IDLE     = 7'b0000001,
    T_ADD      = 7'b0000010,
    T_CUR_GO   = 7'b0000100,
    T_CUR_WAIT = 7'b0001000,
    T_AVG_GO   = 7'b0010000,
    T_AVG_WAIT = 7'b0100000,
    T_OUT      = 7'b1000000
  } top_state_t;

  top_state_t                  state_r;
  logic [wsa_pkg::TIRE_W-1:0]  tire_r;
  logic                        metric_r;
  logic [wsa_pkg::SPEED_W-1:0] cur_r, avg_r;
  logic [wsa_pkg::SPEED_W-1:0] out_cur_r, out_avg_r;
  logic                        out_valid_r;
  logic                        in_acc;
  logic                        out_free;
  wsa_pkg::wnd_status_t        wnd_status;
  wsa_pkg::spd_req_t           spd_req;
  wsa_pkg::spd_rsp_t           spd_rsp;

  assign in_stall  = (state_r != T_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tire_r   <= '0;
      metric_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsa_pkg::CFG_TIRE_SIZE:   tire_r   <= cfg_data;
        wsa_pkg::CFG_METRIC_MODE: metric_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  wsa_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .add_i    (in_acc && (in_req_type == wsa_pkg::REQ_ADD)),
    .count_i  (in_pulse_count),
    .status_o (wnd_status)
  );

  // speed unit request: recent mean first, then window mean
  always_comb begin
    spd_req.start = (state_r == T_CUR_GO)
                 || ((state_r == T_AVG_GO) && (wnd_status.samples != '0));
    spd_req.sum   = (state_r == T_CUR_GO) ? wnd_status.recent_sum : wnd_status.window_sum;
    spd_req.n     = (state_r == T_CUR_GO) ? wsa_pkg::SAMP_W'(3) : wnd_status.samples;
  end

  wsa_speed u_speed (
    .clk      (clk),
    .rst_n    (rst_n),
    .tire_i   (tire_r),
    .metric_i (metric_r),
    .req_i    (spd_req),
    .rsp_o    (spd_rsp)
  );

  // transaction sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            state_r <= (in_req_type == wsa_pkg::REQ_REPORT) ? T_CUR_GO : T_ADD;
          end
        end
        T_ADD:    state_r <= T_IDLE;
        T_CUR_GO: state_r <= T_CUR_WAIT;
        T_CUR_WAIT: begin
          if (spd_rsp.done) begin
            state_r <= T_AVG_GO;
          end
        end
        T_AVG_GO: begin
          state_r <= (wnd_status.samples != '0) ? T_AVG_WAIT : T_OUT;
        end
        T_AVG_WAIT: begin
          if (spd_rsp.done) begin
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // captured speeds
  always_ff @(posedge clk) begin
    if ((state_r == T_CUR_WAIT) && spd_rsp.done) begin
      cur_r <= spd_rsp.speed;
    end
    if (state_r == T_AVG_GO) begin
      avg_r <= '0;
    end else if ((state_r == T_AVG_WAIT) && spd_rsp.done) begin
      avg_r <= spd_rsp.speed;
    end
    if ((state_r == T_OUT) && out_free) begin
      out_cur_r <= cur_r;
      out_avg_r <= avg_r;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == T_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_speed = out_cur_r;
  assign out_average_speed = out_avg_r;

endmodule
